@@ hw/rtl/smbr_pkg.sv @@
package smbr_pkg;

   localparam logic [63:0] GAMMA = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] MUL1  = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] MUL2  = 64'h94D049BB133111EB;
   localparam int unsigned SH1   = 30;
   localparam int unsigned SH2   = 27;
   localparam int unsigned SH3   = 31;

   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_RAW     = 2'd1,
      CMD_BOUNDED = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      OUT_ZERO = 2'd0,
      OUT_RAW  = 2'd1,
      OUT_REM  = 2'd2
   } out_sel_type;

   typedef struct packed {
      logic        accept;
      logic        load_seed;
      logic        mix_start;
      logic        div_start;
      logic        div_sel_limit;
      logic        limit_load;
      logic        out_load;
      out_sel_type out_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic bound_zero;
      logic mix_done;
      logic div_done;
      logic keep;
      logic out_free;
   } dp_stat_type;

endpackage

@@ hw/rtl/smbr_ctrl.sv @@
module smbr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_cmd,
   input  smbr_pkg::dp_stat_type   stat,
   output smbr_pkg::dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_RAW_MIX,
      S_LSTART,
      S_LIMIT,
      S_DRAW,
      S_REDUCE,
      S_OUT
   } state_type;

   state_type              state_ff, state_in;
   smbr_pkg::out_sel_type  out_sel_ff, out_sel_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in          = state_ff;
      out_sel_in        = out_sel_ff;
      cmd               = '0;
      cmd.out_sel       = out_sel_ff;
      cmd.accept        = req_valid && req_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (smbr_pkg::cmd_type'(req_cmd))
                  smbr_pkg::CMD_LOAD: begin
                     cmd.load_seed = 1'b1;
                  end
                  smbr_pkg::CMD_RAW: begin
                     cmd.mix_start = 1'b1;
                     state_in      = S_RAW_MIX;
                  end
                  smbr_pkg::CMD_BOUNDED: begin
                     if (stat.bound_zero) begin
                        out_sel_in = smbr_pkg::OUT_ZERO;
                        state_in   = S_OUT;
                     end else begin
                        state_in   = S_LSTART;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RAW_MIX: begin
            if (stat.mix_done) begin
               out_sel_in = smbr_pkg::OUT_RAW;
               state_in   = S_OUT;
            end
         end
         S_LSTART: begin
            cmd.div_start     = 1'b1;
            cmd.div_sel_limit = 1'b1;
            state_in          = S_LIMIT;
         end
         S_LIMIT: begin
            if (stat.div_done) begin
               cmd.limit_load = 1'b1;
               cmd.mix_start  = 1'b1;
               state_in       = S_DRAW;
            end
         end
         S_DRAW: begin
            if (stat.mix_done) begin
               if (stat.keep) begin
                  cmd.div_start = 1'b1;
                  state_in      = S_REDUCE;
               end else begin
                  cmd.mix_start = 1'b1;
               end
            end
         end
         S_REDUCE: begin
            if (stat.div_done) begin
               out_sel_in = smbr_pkg::OUT_REM;
               state_in   = S_OUT;
            end
         end
         S_OUT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         out_sel_ff <= smbr_pkg::OUT_ZERO;
      end else begin
         state_ff   <= state_in;
         out_sel_ff <= out_sel_in;
      end
   end

endmodule

@@ hw/rtl/smbr_dp.sv @@
module smbr_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [63:0]             req_seed_value,
   input  logic [63:0]             req_upper_bound,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [63:0]             rsp_random_value,
   input  smbr_pkg::dp_cmd_type    cmd,
   output smbr_pkg::dp_stat_type   stat
);

   logic [63:0] gen_ff, gen_in;
   logic [63:0] bound_ff;
   logic [63:0] limit_ff;

   // mixer: one 32x32 multiplier, eight steps per draw
   logic [63:0] mix_a_ff, mix_acc_ff, raw_ff;
   logic [3:0]  step_ff;
   logic        mix_run_ff, mix_done_ff;
   logic [31:0] mul_a, mul_b;
   logic [63:0] product;
   logic [63:0] gen_step;

   // radix-2 remainder unit
   logic [63:0] dvd_ff, rem_ff;
   logic [5:0]  cnt_ff;
   logic        div_run_ff, div_done_ff;
   logic [64:0] trial;
   logic [64:0] trial_diff;

   logic        rsp_valid_ff;
   logic [63:0] rsp_value_ff;

   assign gen_step = gen_ff + smbr_pkg::GAMMA;
   assign gen_in   = cmd.load_seed ? req_seed_value :
                     (cmd.mix_start ? gen_step : gen_ff);

   always_comb begin
      mul_a = mix_a_ff[31:0];
      mul_b = smbr_pkg::MUL1[31:0];
      case (step_ff)
         4'd1: begin
            mul_a = mix_a_ff[31:0];
            mul_b = smbr_pkg::MUL1[31:0];
         end
         4'd2: begin
            mul_a = mix_a_ff[31:0];
            mul_b = smbr_pkg::MUL1[63:32];
         end
         4'd3: begin
            mul_a = mix_a_ff[63:32];
            mul_b = smbr_pkg::MUL1[31:0];
         end
         4'd5: begin
            mul_a = mix_a_ff[31:0];
            mul_b = smbr_pkg::MUL2[31:0];
         end
         4'd6: begin
            mul_a = mix_a_ff[31:0];
            mul_b = smbr_pkg::MUL2[63:32];
         end
         4'd7: begin
            mul_a = mix_a_ff[63:32];
            mul_b = smbr_pkg::MUL2[31:0];
         end
         default: begin
         end
      endcase
   end

   assign product = 64'(mul_a) * 64'(mul_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff      <= '0;
         mix_run_ff  <= 1'b0;
         mix_done_ff <= 1'b0;
         step_ff     <= '0;
      end else begin
         gen_ff      <= gen_in;
         mix_done_ff <= 1'b0;
         if (cmd.mix_start) begin
            mix_run_ff <= 1'b1;
            step_ff    <= 4'd1;
         end else if (mix_run_ff) begin
            if (step_ff == 4'd8) begin
               mix_run_ff  <= 1'b0;
               mix_done_ff <= 1'b1;
            end
            step_ff <= step_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mix_start) begin
         mix_a_ff <= gen_step ^ (gen_step >> smbr_pkg::SH1);
      end else if (mix_run_ff) begin
         case (step_ff)
            4'd1, 4'd5: begin
               mix_acc_ff <= product;
            end
            4'd2, 4'd3, 4'd6, 4'd7: begin
               mix_acc_ff[63:32] <= mix_acc_ff[63:32] + product[31:0];
            end
            4'd4: begin
               mix_a_ff <= mix_acc_ff ^ (mix_acc_ff >> smbr_pkg::SH2);
            end
            4'd8: begin
               raw_ff <= mix_acc_ff ^ (mix_acc_ff >> smbr_pkg::SH3);
            end
            default: begin
            end
         endcase
      end
   end

   assign trial      = {rem_ff, dvd_ff[63]};
   assign trial_diff = trial - {1'b0, bound_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_run_ff  <= 1'b0;
         div_done_ff <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         div_done_ff <= 1'b0;
         if (cmd.div_start) begin
            div_run_ff <= 1'b1;
            cnt_ff     <= '0;
         end else if (div_run_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               div_run_ff  <= 1'b0;
               div_done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dvd_ff <= cmd.div_sel_limit ? (64'd0 - bound_ff) : raw_ff;
         rem_ff <= '0;
      end else if (div_run_ff) begin
         dvd_ff <= {dvd_ff[62:0], 1'b0};
         rem_ff <= trial_diff[64] ? trial[63:0] : trial_diff[63:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         bound_ff <= req_upper_bound;
      end
      if (cmd.limit_load) begin
         limit_ff <= rem_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         case (cmd.out_sel)
            smbr_pkg::OUT_RAW: rsp_value_ff <= raw_ff;
            smbr_pkg::OUT_REM: rsp_value_ff <= rem_ff;
            default:           rsp_value_ff <= '0;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_value_ff;

   assign stat.bound_zero = (req_upper_bound == 64'd0);
   assign stat.mix_done   = mix_done_ff;
   assign stat.div_done   = div_done_ff;
   assign stat.keep       = (raw_ff >= limit_ff);
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

endmodule

@@ hw/rtl/splitmix64_bounded_rng_top.sv @@
// SplitMix64 generator with unbiased bounded draws. Command 0 loads the seed
// and returns nothing; command 3 is accepted and ignored. Command 1 raises
// rsp_valid with one raw draw: the output mix runs through a single shared
// 32x32 multiplier, three partial products per 64-bit multiply. Command 2
// with a nonzero bound repeats draws until one is kept (almost always the
// first): a radix-2 remainder unit, one bit per cycle, first computes the
// rejection threshold (2^64 mod bound) and then reduces the kept draw. A zero
// bound returns 0 and leaves the state unchanged. One item is in work at a
// time; the next one is accepted in the cycle after the result is loaded, and
// the result sits in an output register so the next item can be accepted
// while it waits.
module splitmix64_bounded_rng_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [63:0] req_seed_value,
   input  logic [63:0] req_upper_bound,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_random_value
);

   smbr_pkg::dp_cmd_type  cmd;
   smbr_pkg::dp_stat_type stat;

   smbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .stat      (stat),
      .cmd       (cmd)
   );

   smbr_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_seed_value   (req_seed_value),
      .req_upper_bound  (req_upper_bound),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_random_value (rsp_random_value),
      .cmd              (cmd),
      .stat             (stat)
   );

endmodule

@@ dv/tb_splitmix64_bounded_rng_top.sv @@
`timescale 1ns / 100ps

module tb_splitmix64_bounded_rng_top;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_CYCLES = 200;
   localparam int RANDOM_ITEMS = 1000;
   localparam int TAIL_ITEMS = 150;
   localparam int MAX_REPORTS = 10;
   localparam logic [63:0] TOP_BIT = 64'h8000000000000000;
   localparam logic [63:0] ALL_ONES = 64'hFFFFFFFFFFFFFFFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd = smbr_pkg::CMD_LOAD;
   logic [63:0] req_seed_value = 64'd0;
   logic [63:0] req_upper_bound = 64'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_random_value;

   logic [63:0] rng_state = 64'd0;
   logic [63:0] expected_values[$];
   bit          idle_en = 1'b1;
   int          stall_left = 0;
   int          cycle_count = 0;
   int          fail_count = 0;
   int          results_checked = 0;
   int          work_items = 0;
   int          loads = 0;
   int          raw_draws = 0;
   int          bounded_draws = 0;
   int          refused_draws = 0;
   int          ignored = 0;

   splitmix64_bounded_rng_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_seed_value   (req_seed_value),
      .req_upper_bound  (req_upper_bound),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_random_value (rsp_random_value)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_values.size());
         $display("simulation failed");
         $finish;
      end
   end

   // receiver stalls in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= (stall_left == 1);
      end else if (idle_en && $urandom_range(0, 15) == 0) begin
         stall_left <= $urandom_range(1, 12);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      logic [63:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (expected_values.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("unexpected result %h", rsp_random_value);
         end else begin
            want = expected_values.pop_front();
            if (rsp_random_value !== want) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("result %0d: random_value expected %h, got %h",
                           results_checked, want, rsp_random_value);
            end
         end
      end
   end

   function automatic logic [63:0] next_draw();
      logic [63:0] z;
      rng_state = rng_state + smbr_pkg::GAMMA;
      z = rng_state;
      z = (z ^ (z >> smbr_pkg::SH1)) * smbr_pkg::MUL1;
      z = (z ^ (z >> smbr_pkg::SH2)) * smbr_pkg::MUL2;
      return z ^ (z >> smbr_pkg::SH3);
   endfunction

   function automatic logic [63:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 64'd0;
         1: return ALL_ONES;
         2: return 64'd0 - smbr_pkg::GAMMA;
         3: return {$urandom, $urandom} >> $urandom_range(1, 63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [63:0] pick_bound();
      case ($urandom_range(0, 11))
         0: return 64'd0;
         1: return 64'($urandom_range(1, 16));
         2: return 64'($urandom_range(1, 100000));
         3: return 64'd1 << $urandom_range(0, 63);
         4: return TOP_BIT + 64'($urandom_range(1, 1 << 20));
         5: return ALL_ONES - 64'($urandom_range(0, 1000));
         6, 7: return {$urandom, $urandom} >> $urandom_range(1, 63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // drives one item, waits for its acceptance, then predicts its result
   task automatic send_item(input logic [1:0] cmd, input logic [63:0] seed,
                            input logic [63:0] bound);
      int gap;
      logic [63:0] limit;
      logic [63:0] draw;
      if (idle_en && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_seed_value <= seed;
      req_upper_bound <= bound;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      case (cmd)
         smbr_pkg::CMD_LOAD: begin
            rng_state = seed;
            loads++;
         end
         smbr_pkg::CMD_RAW: begin
            expected_values.push_back(next_draw());
            raw_draws++;
         end
         smbr_pkg::CMD_BOUNDED: begin
            if (bound == 64'd0) begin
               draw = 64'd0;
            end else begin
               limit = (64'd0 - bound) % bound;
               draw = next_draw();
               while (draw < limit) begin
                  refused_draws++;
                  draw = next_draw();
               end
               draw = draw % bound;
            end
            expected_values.push_back(draw);
            bounded_draws++;
         end
         default: ignored++;
      endcase
      if (cmd != CMD_UNUSED)
         work_items++;
   endtask

   task automatic test_after_reset();
      send_item(smbr_pkg::CMD_RAW, pick_word(), pick_word());
      send_item(smbr_pkg::CMD_RAW, pick_word(), pick_word());
      send_item(smbr_pkg::CMD_BOUNDED, pick_word(), 64'd10);
   endtask

   task automatic test_seed_load();
      send_item(smbr_pkg::CMD_LOAD, 64'd0, pick_word());
      send_item(smbr_pkg::CMD_RAW, ALL_ONES, ALL_ONES);
      send_item(smbr_pkg::CMD_LOAD, ALL_ONES, pick_word());
      send_item(smbr_pkg::CMD_RAW, 64'd0, 64'd0);
      // state wraps to zero on the next step
      send_item(smbr_pkg::CMD_LOAD, 64'd0 - smbr_pkg::GAMMA, pick_word());
      send_item(smbr_pkg::CMD_RAW, pick_word(), pick_word());
      send_item(smbr_pkg::CMD_RAW, pick_word(), pick_word());
      send_item(smbr_pkg::CMD_LOAD, {$urandom, $urandom}, pick_word());
      send_item(smbr_pkg::CMD_LOAD, {$urandom, $urandom}, pick_word());
      send_item(smbr_pkg::CMD_RAW, pick_word(), pick_word());
   endtask

   task automatic test_bounded_edges();
      send_item(smbr_pkg::CMD_BOUNDED, pick_word(), 64'd0);
      send_item(smbr_pkg::CMD_RAW, pick_word(), pick_word());
      send_item(smbr_pkg::CMD_BOUNDED, pick_word(), 64'd1);
      send_item(smbr_pkg::CMD_BOUNDED, pick_word(), 64'd2);
      send_item(smbr_pkg::CMD_BOUNDED, pick_word(), 64'd3);
      send_item(smbr_pkg::CMD_BOUNDED, pick_word(), TOP_BIT);
      // threshold near 2^63: about half of the draws are refused
      send_item(smbr_pkg::CMD_BOUNDED, pick_word(), TOP_BIT + 64'd1);
      send_item(smbr_pkg::CMD_BOUNDED, pick_word(), TOP_BIT + 64'd1);
      send_item(smbr_pkg::CMD_BOUNDED, pick_word(), ALL_ONES);
      send_item(smbr_pkg::CMD_BOUNDED, pick_word(), ALL_ONES - 64'd1);
      send_item(smbr_pkg::CMD_BOUNDED, pick_word(), 64'd0);
   endtask

   task automatic test_unused_cmd();
      send_item(CMD_UNUSED, ALL_ONES, 64'd0);
      send_item(smbr_pkg::CMD_RAW, pick_word(), pick_word());
      send_item(CMD_UNUSED, 64'd0, ALL_ONES);
      send_item(smbr_pkg::CMD_BOUNDED, pick_word(), 64'd7);
   endtask

   task automatic test_random_mix(input int count, input bit allow_idle);
      int target;
      int pick;
      target = work_items + count;
      idle_en = allow_idle;
      while (work_items < target) begin
         if (allow_idle && work_items % 64 == 0)
            idle_en = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 19);
         if (pick < 2)
            send_item(smbr_pkg::CMD_LOAD, pick_word(), pick_word());
         else if (pick < 9)
            send_item(smbr_pkg::CMD_RAW, pick_word(), pick_word());
         else if (pick < 19)
            send_item(smbr_pkg::CMD_BOUNDED, pick_word(), pick_bound());
         else
            send_item(CMD_UNUSED, pick_word(), pick_word());
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_after_reset();
      test_seed_load();
      test_bounded_edges();
      test_unused_cmd();
      test_random_mix(RANDOM_ITEMS, 1'b1);
      test_random_mix(TAIL_ITEMS, 1'b0);
      req_valid <= 1'b0;
      while (expected_values.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d seed loads, %0d raw and %0d bounded draws (%0d draws refused), %0d unused",
               loads, raw_draws, bounded_draws, refused_draws, ignored);
      $display("%0d results checked, %0d failures", results_checked, fail_count);
      if (fail_count == 0 && expected_values.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/smbr_pkg.sv
hw/rtl/smbr_ctrl.sv
hw/rtl/smbr_dp.sv
hw/rtl/splitmix64_bounded_rng_top.sv
dv/tb_splitmix64_bounded_rng_top.sv
